// ===== rtl/bsrt_pkg.sv =====
// Shared constants, field layout and command codes of the bad-segment remapper.
`default_nettype none

package bsrt_pkg;

	// Default geometry.
	localparam int USED_SEGMENTS_DEF     = 64;
	localparam int RAW_SEGMENTS_DEF      = 128;
	localparam int SEGMENT_PAGE_BITS_DEF = 14;

	// Field widths of one input word and one result word.
	localparam int CMD_W       = 2;
	localparam int SEG_FIELD_W = 7;
	localparam int ADDR_W      = 20;
	localparam int MAP_W       = 21;

	// Positions inside the input tdata.
	localparam int IN_SEG_LSB  = 0;
	localparam int IN_BAD_BIT  = 7;
	localparam int IN_ADDR_LSB = 8;
	localparam int IN_TDATA_W  = 32;

	// Positions inside the output tdata.
	localparam int OUT_STATUS_BIT = 21;
	localparam int OUT_TDATA_W    = 24;

	// SLC page fold layout: bus and chip below the page, block above it.
	localparam int           FOLD_PAGE_LSB    = 6;
	localparam int           FOLD_PAGE_W      = 8;
	localparam int           FOLD_BLOCK_SHIFT = 14;
	localparam logic [7:0]   FOLD_PAGE_MASK   = 8'hFF;
	localparam logic [7:0]   FOLD_TOP_PAGE    = 8'd254;
	localparam logic [7:0]   FOLD_LOW_PAGE    = 8'd4;
	localparam logic [7:0]   FOLD_TOP_DROP    = 8'd4;
	localparam logic [7:0]   FOLD_MID_DROP    = 8'd6;

	typedef enum logic [CMD_W-1:0] {
		CMD_MARK      = 2'd0,
		CMD_BUILD     = 2'd1,
		CMD_TRANSLATE = 2'd2
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bad_segment_remap_table.sv =====
// Top level of the flash bad-segment remapper: sequencer, flag and spare tables.
//
//   Channel  | Direction | Handshake                    | Content
//   ---------+-----------+------------------------------+-----------------------------------
//   cfg      | in        | cfg_valid / cfg_ready        | cfg_data = slc_fold_enable
//   s_axis   | in        | s_axis_tvalid / s_axis_tready| tuser = command, tdata = fields
//   m_axis   | out       | m_axis_tvalid / m_axis_tready| tdata = mapped_address, status
//
// For a mark or translate word the accept cycle issues one read of the flag
// RAM (and the spare RAM), and the next cycle decides and writes.
// A build word walks the used segments with one shared back-index compare:
// it reads and checks each used segment, then each spare candidate looked at,
// and ends after the last used segment or on an overflow.
// Reset clears the bad flags at once through per-entry valid flip-flops; the
// spare table holds nothing defined until a build writes it.
// The result sits in an output register; a stalled output holds the word in
// a one-entry buffer state, and no new input word is taken while it is there.
`default_nettype none

module bad_segment_remap_table #(
	parameter int USED_SEGMENTS     = bsrt_pkg::USED_SEGMENTS_DEF,
	parameter int RAW_SEGMENTS      = bsrt_pkg::RAW_SEGMENTS_DEF,
	parameter int SEGMENT_PAGE_BITS = bsrt_pkg::SEGMENT_PAGE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration: slc_fold_enable.
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic                               cfg_data,
	// Input words.
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// tdata from bit 0: segment[6:0], is_bad[7], address[27:8], zero pad [31:28].
	input  wire logic [bsrt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// tuser: command[1:0].
	input  wire logic [bsrt_pkg::CMD_W-1:0]         s_axis_tuser,
	// Result words.
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// tdata from bit 0: mapped_address[20:0], status[21], zero pad [23:22].
	output logic      [bsrt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	// Widths that follow from the geometry.
	localparam int RAW_AW      = $clog2(RAW_SEGMENTS);
	localparam int USED_AW     = (USED_SEGMENTS > 1) ? $clog2(USED_SEGMENTS) : 1;
	localparam int I_W         = $clog2(USED_SEGMENTS + 1);
	localparam int SRC_BLOCK_W = bsrt_pkg::ADDR_W - bsrt_pkg::FOLD_BLOCK_SHIFT;
	localparam int BLOCK_W     = ((SRC_BLOCK_W > I_W) ? SRC_BLOCK_W : I_W) + 1;
	localparam int FOLD_W      = bsrt_pkg::FOLD_BLOCK_SHIFT + BLOCK_W;
	localparam int SEG_W       = FOLD_W - SEGMENT_PAGE_BITS;
	localparam int SPARE_W     = RAW_AW + SEGMENT_PAGE_BITS;
	localparam int RES_A_W     = (FOLD_W > SPARE_W) ? FOLD_W : SPARE_W;
	localparam int RES_W       = (RES_A_W > bsrt_pkg::MAP_W) ? RES_A_W : bsrt_pkg::MAP_W;
	localparam int CMP_A_W     = (I_W > RAW_AW + 1) ? I_W : RAW_AW + 1;
	localparam int CMP_W       = CMP_A_W + 1;
	localparam int PAD_W       = bsrt_pkg::OUT_TDATA_W - bsrt_pkg::MAP_W - 1;

	localparam logic signed [RAW_AW:0] BACK_TOP = (RAW_AW + 1)'(RAW_SEGMENTS - 1);
	localparam logic signed [RAW_AW:0] BACK_ONE = (RAW_AW + 1)'(1);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_LOOK   = 7'b0000010,
		ST_RESP   = 7'b0000100,
		ST_B_RDI  = 7'b0001000,
		ST_B_CHKI = 7'b0010000,
		ST_B_RDB  = 7'b0100000,
		ST_B_CHKB = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Input word fields.
	bsrt_pkg::cmd_t                      cmd_in;
	logic [bsrt_pkg::SEG_FIELD_W-1:0]    seg_in;
	logic                                bad_in;
	logic [bsrt_pkg::ADDR_W-1:0]         addr_in;
	logic                                in_acc;

	// Registered word and configuration.
	bsrt_pkg::cmd_t                      cmd_q;
	logic                                bad_q;
	logic [FOLD_W-1:0]                   fold_q;
	logic                                fold_en_q;

	// Fold and lookup.
	logic [FOLD_W-1:0]                   fold_w;
	logic [SEG_W-1:0]                    fold_seg_w;

	// Flag RAM read port and valid bits.
	logic [RAW_AW-1:0]                   rd_addr_d, rd_addr_q;
	logic                                rd_inr_d, rd_inr_q;
	logic [RAW_SEGMENTS-1:0]             flag_vld_q;
	logic                                flag_rdata;
	logic                                flag_hit;
	logic                                flag_we;

	// Spare table.
	logic [RAW_AW-1:0]                   spare_rdata;
	logic                                spare_we;

	// Build walk: used index and back index of the spare search.
	logic [I_W-1:0]                      i_q, i_nxt;
	logic signed [RAW_AW:0]              back_q;
	logic signed [CMP_W-1:0]             back_x, i_x;
	logic                                back_lt_i;
	logic                                i_last;
	logic                                i_inc, back_dec, walk_init;
	logic                                bld_fin, bld_fail;

	// Results.
	logic [RES_W-1:0]                    remap_wide;
	logic [bsrt_pkg::MAP_W-1:0]          look_mapped;
	logic [bsrt_pkg::MAP_W-1:0]          res_mapped_q, out_mapped_q;
	logic                                res_status_q, out_status_q;
	logic                                out_valid_q;
	logic                                out_free;
	logic                                out_load;

	// ------------------------------------------------------------------
	// Handshakes and field unpacking.
	// ------------------------------------------------------------------
	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign cmd_in  = bsrt_pkg::cmd_t'(s_axis_tuser);
	assign seg_in  = s_axis_tdata[bsrt_pkg::IN_SEG_LSB +: bsrt_pkg::SEG_FIELD_W];
	assign bad_in  = s_axis_tdata[bsrt_pkg::IN_BAD_BIT];
	assign addr_in = s_axis_tdata[bsrt_pkg::IN_ADDR_LSB +: bsrt_pkg::ADDR_W];

	// The fold runs on the incoming word so that the table reads go out in
	// the accept cycle.
	bsrt_fold #(
		.USED_SEGMENTS (USED_SEGMENTS),
		.BLOCK_W       (BLOCK_W)
	) u_fold (
		.address (addr_in),
		.enable  (fold_en_q),
		.folded  (fold_w)
	);

	assign fold_seg_w = fold_w[FOLD_W-1:SEGMENT_PAGE_BITS];

	// ------------------------------------------------------------------
	// Flag RAM read address. The range flag travels with the address so
	// that an index outside the table always reads as a good segment.
	// ------------------------------------------------------------------
	always_comb begin
		rd_addr_d = '0;
		rd_inr_d  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_in == bsrt_pkg::CMD_MARK) begin
					rd_addr_d = RAW_AW'(seg_in);
					rd_inr_d  = (seg_in < RAW_SEGMENTS);
				end else begin
					rd_addr_d = RAW_AW'(fold_seg_w);
					rd_inr_d  = (fold_seg_w < USED_SEGMENTS) && (fold_seg_w < RAW_SEGMENTS);
				end
			end
			ST_B_RDI: begin
				rd_addr_d = RAW_AW'(i_q);
				rd_inr_d  = (i_q < RAW_SEGMENTS);
			end
			ST_B_RDB: begin
				rd_addr_d = RAW_AW'(back_q);
				rd_inr_d  = !back_q[RAW_AW];
			end
			default: begin
				rd_addr_d = '0;
				rd_inr_d  = 1'b0;
			end
		endcase
	end

	bsrt_ram #(
		.WIDTH (1),
		.DEPTH (RAW_SEGMENTS)
	) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (rd_addr_q),
		.wdata (bad_q),
		.raddr (rd_addr_d),
		.rdata (flag_rdata)
	);

	// A never-written entry reads as good.
	assign flag_hit = rd_inr_q && flag_vld_q[rd_addr_q] && flag_rdata;

	bsrt_ram #(
		.WIDTH (RAW_AW),
		.DEPTH (USED_SEGMENTS)
	) u_spare_ram (
		.clk   (clk),
		.we    (spare_we),
		.waddr (USED_AW'(i_q)),
		.wdata (RAW_AW'(back_q)),
		.raddr (USED_AW'(fold_seg_w)),
		.rdata (spare_rdata)
	);

	// ------------------------------------------------------------------
	// Shared compare of the build walk: the back index against the used
	// index. It serves both the overflow check before the search and the
	// one after skipping bad spare candidates.
	// ------------------------------------------------------------------
	assign back_x    = CMP_W'(back_q);
	assign i_x       = CMP_W'(i_q);
	assign back_lt_i = (back_x < i_x);
	assign i_nxt     = i_q + I_W'(1);
	assign i_last    = (i_nxt == I_W'(USED_SEGMENTS));

	// ------------------------------------------------------------------
	// Translate result: swap the segment base, keep the page offset.
	// ------------------------------------------------------------------
	assign remap_wide = (RES_W'(spare_rdata) << SEGMENT_PAGE_BITS)
		| RES_W'(fold_q[SEGMENT_PAGE_BITS-1:0]);

	always_comb begin
		case (cmd_q)
			bsrt_pkg::CMD_TRANSLATE: begin
				look_mapped = flag_hit ? bsrt_pkg::MAP_W'(remap_wide)
					: bsrt_pkg::MAP_W'(fold_q);
			end
			default: look_mapped = '0;
		endcase
	end

	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = ((state_q == ST_LOOK) || (state_q == ST_RESP)) && out_free;

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		flag_we   = 1'b0;
		spare_we  = 1'b0;
		i_inc     = 1'b0;
		back_dec  = 1'b0;
		walk_init = 1'b0;
		bld_fin   = 1'b0;
		bld_fail  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (cmd_in == bsrt_pkg::CMD_BUILD) begin
						walk_init = 1'b1;
						state_d   = ST_B_RDI;
					end else begin
						state_d = ST_LOOK;
					end
				end
			end
			ST_LOOK: begin
				// A flag that is already set stays set.
				flag_we = (cmd_q == bsrt_pkg::CMD_MARK) && rd_inr_q && !flag_hit;
				state_d = out_free ? ST_IDLE : ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_B_RDI: begin
				state_d = ST_B_CHKI;
			end
			ST_B_CHKI: begin
				if (!flag_hit) begin
					if (i_last) begin
						bld_fin = 1'b1;
						state_d = ST_RESP;
					end else begin
						i_inc   = 1'b1;
						state_d = ST_B_RDI;
					end
				end else if (back_lt_i) begin
					bld_fin  = 1'b1;
					bld_fail = 1'b1;
					state_d  = ST_RESP;
				end else begin
					state_d = ST_B_RDB;
				end
			end
			ST_B_RDB: begin
				if (back_q[RAW_AW]) begin
					// Every candidate down to zero was bad.
					bld_fin  = 1'b1;
					bld_fail = 1'b1;
					state_d  = ST_RESP;
				end else begin
					state_d = ST_B_CHKB;
				end
			end
			ST_B_CHKB: begin
				if (flag_hit) begin
					back_dec = 1'b1;
					state_d  = ST_B_RDB;
				end else if (back_lt_i) begin
					bld_fin  = 1'b1;
					bld_fail = 1'b1;
					state_d  = ST_RESP;
				end else begin
					spare_we = 1'b1;
					back_dec = 1'b1;
					if (i_last) begin
						bld_fin = 1'b1;
						state_d = ST_RESP;
					end else begin
						i_inc   = 1'b1;
						state_d = ST_B_RDI;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			back_q      <= BACK_TOP;
			rd_inr_q    <= 1'b0;
			flag_vld_q  <= '0;
			fold_en_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_inr_q <= rd_inr_d;
			if (cfg_valid && cfg_ready) begin
				fold_en_q <= cfg_data;
			end
			if (flag_we) begin
				flag_vld_q[rd_addr_q] <= 1'b1;
			end
			if (walk_init) begin
				i_q    <= '0;
				back_q <= BACK_TOP;
			end else begin
				if (i_inc) begin
					i_q <= i_nxt;
				end
				if (back_dec) begin
					back_q <= back_q - BACK_ONE;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr_d;
		if (in_acc) begin
			cmd_q  <= cmd_in;
			bad_q  <= bad_in;
			fold_q <= fold_w;
		end
		if ((state_q == ST_LOOK) && !out_free) begin
			res_mapped_q <= look_mapped;
			res_status_q <= 1'b0;
		end else if (bld_fin) begin
			res_mapped_q <= '0;
			res_status_q <= bld_fail;
		end
		if (out_load) begin
			if (state_q == ST_LOOK) begin
				out_mapped_q <= look_mapped;
				out_status_q <= 1'b0;
			end else begin
				out_mapped_q <= res_mapped_q;
				out_status_q <= res_status_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {PAD_W'(0), out_status_q, out_mapped_q};

endmodule

`default_nettype wire

// ===== rtl/bsrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bsrt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bsrt_fold.sv =====
// SLC page fold of a page address ahead of the remap lookup.
`default_nettype none

module bsrt_fold #(
	parameter int USED_SEGMENTS = bsrt_pkg::USED_SEGMENTS_DEF,
	parameter int BLOCK_W       = 7
) (
	input  wire logic [bsrt_pkg::ADDR_W-1:0]                    address,
	input  wire logic                                          enable,
	output logic      [bsrt_pkg::FOLD_BLOCK_SHIFT+BLOCK_W-1:0] folded
);

	localparam int FOLD_W = bsrt_pkg::FOLD_BLOCK_SHIFT + BLOCK_W;
	localparam int SRC_BLOCK_W = bsrt_pkg::ADDR_W - bsrt_pkg::FOLD_BLOCK_SHIFT;

	logic [bsrt_pkg::FOLD_PAGE_W-1:0] page;
	logic [bsrt_pkg::FOLD_PAGE_W-1:0] page_n;
	logic [SRC_BLOCK_W-1:0]           block;
	logic [BLOCK_W-1:0]               block_n;
	logic                             moved;

	assign page  = address[bsrt_pkg::FOLD_BLOCK_SHIFT-1:bsrt_pkg::FOLD_PAGE_LSB]
		& bsrt_pkg::FOLD_PAGE_MASK;
	assign block = address[bsrt_pkg::ADDR_W-1:bsrt_pkg::FOLD_BLOCK_SHIFT];

	always_comb begin
		page_n = page;
		moved  = 1'b0;
		if (page >= bsrt_pkg::FOLD_TOP_PAGE) begin
			page_n = page - bsrt_pkg::FOLD_TOP_DROP;
			moved  = 1'b1;
		end else if (page >= bsrt_pkg::FOLD_LOW_PAGE && !page[1]) begin
			// Pages 0 and 1 of each group of four sit in the folded region.
			if (page > bsrt_pkg::FOLD_MID_DROP) begin
				page_n = page - bsrt_pkg::FOLD_MID_DROP;
			end
			moved = 1'b1;
		end
		block_n = BLOCK_W'(block) + (moved ? BLOCK_W'(USED_SEGMENTS) : BLOCK_W'(0));
	end

	assign folded = enable
		? {block_n, page_n, address[bsrt_pkg::FOLD_PAGE_LSB-1:0]}
		: FOLD_W'(address);

endmodule

`default_nettype wire

// ===== rtl/bsrt_checker.sv =====
// Port-level checks of the bad-segment remapper, bound to the top level.
`default_nettype none

module bsrt_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [bsrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// No new word is taken in the cycle after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after an accept");

	// Overflow is only reported by a build, whose address field is zero.
	a_status_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[bsrt_pkg::OUT_STATUS_BIT])
		|-> (m_axis_tdata[bsrt_pkg::MAP_W-1:0] == '0))
		else $error("status set with a nonzero address");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

endmodule

bind bad_segment_remap_table bsrt_checker u_bsrt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
